FILE: src/pdrd_pkg.sv
// ----------------------------------------------------------------------------
// pdrd_pkg: shared types and constants of the packed delta row decoder
// Holds the queue entry format, the escape codes and the status codes.
// ----------------------------------------------------------------------------
package pdrd_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	// Byte codes of a first pixel or a tail delta that open an escape.
	localparam logic [7:0] BYTE_ESC_LONG  = 8'd255;
	localparam logic [7:0] BYTE_ESC_SHORT = 8'd254;
	localparam logic [31:0] BYTE_BIAS     = 32'd127;

	// Block delta values that open an escape.
	localparam logic signed [8:0] DELTA_ESC_LONG  = 9'sd128;
	localparam logic signed [8:0] DELTA_ESC_SHORT = 9'sd127;

	localparam logic [3:0] MAX_FIELD_WIDTH = 4'd8;
	localparam logic [3:0] LAST_DELTA      = 4'd15;
	localparam logic [15:0] BLOCK_PIXELS   = 16'd16;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_WIDTH = 2'd1,
		ST_RESTART   = 2'd2
	} status_t;

	// One queued input byte, already classified by the front end.
	typedef struct packed {
		logic [7:0] data;
		logic       row_start;
		logic       esc_long;
		logic       esc_short;
	} item_t;

	// One result beat.
	typedef struct packed {
		logic [31:0] pixel;
		logic        row_end;
		logic        run_last;
		status_t     status;
	} result_t;

endpackage

FILE: src/pdrd_front.sv
// ----------------------------------------------------------------------------
// pdrd_front: input acceptance and classification
// Takes input beats, marks escape codes and holds them in a short queue.
// ----------------------------------------------------------------------------
module pdrd_front import pdrd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t           entries [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	item_t           in_item;

	assign s_tready = count_q != CW'(QUEUE_DEPTH);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = count_q != '0;
	assign q_item   = entries[rd_ptr_q];

	always_comb begin
		in_item.data      = s_tdata;
		in_item.row_start = s_tuser;
		in_item.esc_long  = s_tdata == BYTE_ESC_LONG;
		in_item.esc_short = s_tdata == BYTE_ESC_SHORT;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/pdrd_back.sv
// ----------------------------------------------------------------------------
// pdrd_back: row decoder and result register
// Consumes queued bytes, unpacks delta blocks and accumulates pixels.
// ----------------------------------------------------------------------------
module pdrd_back import pdrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] row_width,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output result_t     m_result
);

	typedef enum logic [8:0] {
		S_WAIT = 9'b000000001,
		S_FESC = 9'b000000010,
		S_HDR  = 9'b000000100,
		S_PACK = 9'b000001000,
		S_ADV  = 9'b000010000,
		S_RES  = 9'b000100000,
		S_BESC = 9'b001000000,
		S_TAIL = 9'b010000000,
		S_TESC = 9'b100000000
	} state_t;

	state_t            state_q, n_state, eff;
	logic [31:0]       last_q, n_last;
	logic [15:0]       pl_q, n_pl;
	logic [7:0]        bw_q, n_bw;
	logic [63:0]       packed_q, n_packed;
	logic [3:0]        pcnt_q, n_pcnt;
	logic [1:0]        half_q, n_half;
	logic [2:0]        j_q, n_j;
	logic [3:0]        idx_q, n_idx;
	logic [31:0]       asm_q, n_asm;
	logic [1:0]        ecnt_q, n_ecnt;
	logic              elong_q, n_elong;
	logic              bad_q, n_bad;
	logic              restart_q, n_restart;
	logic signed [8:0] dbuf [16];
	logic [15:0]       esc_q;

	logic              buf_we;
	logic [3:0]        buf_wa;
	logic signed [8:0] buf_wd;
	logic              ov_free, consume, rst_now, emit, look;
	result_t           e_res;
	logic [31:0]       esc_asm, esc_val, b_delta, d_ext;
	logic              esc_done;
	logic [15:0]       w_eff, pl_first, pl_dec;
	logic [3:0]        nb, nidx;
	logic [7:0]        field;
	logic [8:0]        bias;
	logic signed [8:0] dnew, dcur;

	function automatic state_t next_sec(input logic [15:0] pl);
		if (pl >= BLOCK_PIXELS) begin
			return S_HDR;
		end else if (pl != 16'd0) begin
			return S_TAIL;
		end
		return S_WAIT;
	endfunction

	assign ov_free = !m_tvalid || m_tready;
	assign consume = (state_q == S_WAIT) || (state_q == S_FESC) || (state_q == S_HDR)
		|| (state_q == S_PACK) || (state_q == S_BESC) || (state_q == S_TAIL)
		|| (state_q == S_TESC);

	always_comb begin
		esc_asm  = asm_q | (32'(q_item.data) << {ecnt_q, 3'b000});
		esc_done = elong_q ? (ecnt_q == 2'd3) : (ecnt_q == 2'd1);
		esc_val  = elong_q ? esc_asm : {{16{esc_asm[15]}}, esc_asm[15:0]};
		b_delta  = 32'(q_item.data) - BYTE_BIAS;
		w_eff    = (row_width == 16'd0) ? 16'd1 : row_width;
		pl_first = w_eff - 16'd1;
		pl_dec   = pl_q - 16'd1;
		nidx     = idx_q + 4'd1;
		look     = (idx_q == LAST_DELTA) || esc_q[nidx];
		nb       = half_q[0] ? bw_q[7:4] : bw_q[3:0];
		field    = packed_q[7:0] & 8'((9'd1 << nb) - 9'd1);
		bias     = (nb > 4'd1) ? ((9'd1 << (nb - 4'd1)) - 9'd1) : 9'd0;
		dnew     = $signed({1'b0, field} - bias);
		dcur     = dbuf[idx_q];
		d_ext    = {{23{dcur[8]}}, dcur};
	end

	always_comb begin
		n_state   = state_q;
		n_last    = last_q;
		n_pl      = pl_q;
		n_bw      = bw_q;
		n_packed  = packed_q;
		n_pcnt    = pcnt_q;
		n_half    = half_q;
		n_j       = j_q;
		n_idx     = idx_q;
		n_asm     = asm_q;
		n_ecnt    = ecnt_q;
		n_elong   = elong_q;
		n_bad     = bad_q;
		n_restart = restart_q;
		q_pop     = 1'b0;
		emit      = 1'b0;
		e_res     = '{pixel: 32'd0, row_end: 1'b0, run_last: 1'b1, status: ST_OK};
		buf_we    = 1'b0;
		buf_wa    = {half_q[0], j_q};
		buf_wd    = dnew;
		eff       = state_q;
		rst_now   = restart_q;
		if (consume && q_valid && ov_free) begin
			q_pop = 1'b1;
			if (q_item.row_start) begin
				eff = S_WAIT;
				if (state_q != S_WAIT) begin
					rst_now = 1'b1;
				end
			end
			n_restart = rst_now;
			case (eff)
				S_WAIT: begin
					if (q_item.row_start) begin
						if (q_item.esc_long || q_item.esc_short) begin
							n_elong = q_item.esc_long;
							n_ecnt  = 2'd0;
							n_asm   = 32'd0;
							n_state = S_FESC;
						end else begin
							emit      = 1'b1;
							e_res     = '{pixel: b_delta, row_end: pl_first == 16'd0,
								run_last: 1'b1, status: rst_now ? ST_RESTART : ST_OK};
							n_restart = 1'b0;
							n_last    = b_delta;
							n_pl      = pl_first;
							n_state   = next_sec(pl_first);
						end
					end
				end
				S_FESC: begin
					n_asm  = esc_asm;
					n_ecnt = ecnt_q + 2'd1;
					if (esc_done) begin
						emit      = 1'b1;
						e_res     = '{pixel: esc_val, row_end: pl_first == 16'd0,
							run_last: 1'b1, status: rst_now ? ST_RESTART : ST_OK};
						n_restart = 1'b0;
						n_last    = esc_val;
						n_pl      = pl_first;
						n_state   = next_sec(pl_first);
					end
				end
				S_HDR: begin
					n_bw     = q_item.data;
					n_bad    = 1'b0;
					n_half   = 2'd0;
					n_pcnt   = 4'd0;
					n_packed = 64'd0;
					n_j      = 3'd0;
					n_state  = S_ADV;
				end
				S_PACK: begin
					if (pcnt_q < 4'd8) begin
						n_packed = packed_q | (64'(q_item.data) << {pcnt_q[2:0], 3'b000});
					end
					n_pcnt  = pcnt_q + 4'd1;
					n_state = S_ADV;
				end
				S_BESC: begin
					n_asm  = esc_asm;
					n_ecnt = ecnt_q + 2'd1;
					if (esc_done) begin
						emit   = 1'b1;
						e_res  = '{pixel: last_q + esc_val, row_end: pl_dec == 16'd0,
							run_last: look, status: bad_q ? ST_BAD_WIDTH : ST_OK};
						n_last = last_q + esc_val;
						n_pl   = pl_dec;
						if (idx_q == LAST_DELTA) begin
							n_state = next_sec(pl_dec);
						end else begin
							n_idx   = nidx;
							n_state = S_RES;
						end
					end
				end
				S_TAIL: begin
					if (q_item.esc_long || q_item.esc_short) begin
						n_elong = q_item.esc_long;
						n_ecnt  = 2'd0;
						n_asm   = 32'd0;
						n_state = S_TESC;
					end else begin
						emit    = 1'b1;
						e_res   = '{pixel: last_q + b_delta, row_end: pl_dec == 16'd0,
							run_last: 1'b1, status: ST_OK};
						n_last  = last_q + b_delta;
						n_pl    = pl_dec;
						n_state = next_sec(pl_dec);
					end
				end
				S_TESC: begin
					n_asm  = esc_asm;
					n_ecnt = ecnt_q + 2'd1;
					if (esc_done) begin
						emit    = 1'b1;
						e_res   = '{pixel: last_q + esc_val, row_end: pl_dec == 16'd0,
							run_last: 1'b1, status: ST_OK};
						n_last  = last_q + esc_val;
						n_pl    = pl_dec;
						n_state = next_sec(pl_dec);
					end
				end
				default: begin
					n_state = S_WAIT;
				end
			endcase
		end else if (state_q == S_ADV) begin
			if (half_q[1]) begin
				n_idx   = 4'd0;
				n_state = S_RES;
			end else if (pcnt_q >= nb) begin
				// One delta of the current half per cycle.
				buf_we = 1'b1;
				if (nb > MAX_FIELD_WIDTH) begin
					n_bad  = 1'b1;
					buf_wd = 9'sd0;
				end
				n_packed = packed_q >> nb;
				n_j      = j_q + 3'd1;
				if (j_q == 3'd7) begin
					n_half   = half_q + 2'd1;
					n_pcnt   = 4'd0;
					n_packed = 64'd0;
				end
			end else begin
				n_state = S_PACK;
			end
		end else if (state_q == S_RES && ov_free) begin
			if (esc_q[idx_q]) begin
				n_elong = dcur == DELTA_ESC_LONG;
				n_ecnt  = 2'd0;
				n_asm   = 32'd0;
				n_state = S_BESC;
			end else begin
				emit   = 1'b1;
				e_res  = '{pixel: last_q + d_ext, row_end: pl_dec == 16'd0,
					run_last: look, status: bad_q ? ST_BAD_WIDTH : ST_OK};
				n_last = last_q + d_ext;
				n_pl   = pl_dec;
				if (idx_q == LAST_DELTA) begin
					n_state = next_sec(pl_dec);
				end else begin
					n_idx = nidx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			dbuf[buf_wa] <= buf_wd;
		end
		if (emit) begin
			m_result <= e_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_WAIT;
			last_q    <= 32'd0;
			pl_q      <= 16'd0;
			bw_q      <= 8'd0;
			packed_q  <= 64'd0;
			pcnt_q    <= 4'd0;
			half_q    <= 2'd0;
			j_q       <= 3'd0;
			idx_q     <= 4'd0;
			asm_q     <= 32'd0;
			ecnt_q    <= 2'd0;
			elong_q   <= 1'b0;
			bad_q     <= 1'b0;
			restart_q <= 1'b0;
			esc_q     <= 16'd0;
			m_tvalid  <= 1'b0;
		end else begin
			state_q   <= n_state;
			last_q    <= n_last;
			pl_q      <= n_pl;
			bw_q      <= n_bw;
			packed_q  <= n_packed;
			pcnt_q    <= n_pcnt;
			half_q    <= n_half;
			j_q       <= n_j;
			idx_q     <= n_idx;
			asm_q     <= n_asm;
			ecnt_q    <= n_ecnt;
			elong_q   <= n_elong;
			bad_q     <= n_bad;
			restart_q <= n_restart;
			if (buf_we) begin
				esc_q[buf_wa] <= (buf_wd == DELTA_ESC_LONG) || (buf_wd == DELTA_ESC_SHORT);
			end
			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	// A byte is only taken when the result register can absorb a beat.
	a_pop_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> ov_free) else $error("byte popped without result room");

	// Every delta left in a block still has a pixel of the row behind it.
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES) |-> ((17'(pl_q) + 17'(idx_q)) >= 17'd16))
		else $error("block outruns row length");

	// Bad-width status only comes out of block delta resolution.
	a_bad_src: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_res.status == ST_BAD_WIDTH) |-> (state_q == S_RES || state_q == S_BESC))
		else $error("bad-width status outside a block");

	// The delta sub-counter rests at zero outside the unpack state.
	a_j_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_ADV) |-> (j_q == 3'd0)) else $error("unpack counter left running");

endmodule

FILE: src/packed_delta_row_decoder_unit.sv
// ----------------------------------------------------------------------------
// packed_delta_row_decoder_unit: packed delta row decoder, top level
// Rebuilds 32-bit signed detector pixels from a compressed byte stream.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  s_*      in         tdata[7:0] data byte; tuser[0] row start
//  m_*      out        tdata[31:0] pixel; tlast row end; tuser[0] last beat of the
//                      input byte, tuser[2:1] status (0 ok, 1 bad width, 2 restart)
//  cfg_*    in         cfg_wdata row width in pixels, written when cfg_we is high
//
// A plain byte (first pixel, tail delta, header or escape byte) is handled as it is taken.
// A block takes its header byte, a fill check and a fetch for each packed byte, an
// unpack of its 16 deltas (one delta per cycle), a start of resolution and then one
// pixel per delta; an escaped delta is opened and then takes its escape bytes, the
// last of which also gives its pixel. The result register is the only output stage: a
// byte is consumed only when it can take a beat, so output stalls back up into the queue.
// Reset is asynchronous and active low; the row width resets to one pixel.
//
module packed_delta_row_decoder_unit import pdrd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] row_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] pixel
	output logic        m_tlast,
	output logic [2:0]  m_tuser,   // [0] run_last, [2:1] status
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] row_width_q;
	logic        q_valid;
	logic        q_pop;
	item_t       q_item;
	result_t     res;

	// The row width register; the decoder samples it on each row's first pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= 16'd1;
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	// The front end queues classified bytes so that input can keep arriving while
	// the back end is unpacking a block or waiting on the output.
	pdrd_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	pdrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_width (row_width_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_result  (res)
	);

	assign m_tdata = res.pixel;
	assign m_tlast = res.row_end;
	assign m_tuser = {res.status, res.run_last};

endmodule

FILE: dv/pdrd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdrd_checker: pixel predictor and scoreboard of the packed delta row decoder
// Watches the byte, pixel and width-write ports. Each accepted byte is decoded
// by its own model into expected pixel beats, and each pixel beat is checked
// field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module pdrd_checker import pdrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	output int          fails,
	output int          pending
);

	typedef enum logic [2:0] {
		P_WAIT, P_FIRST_ESC, P_HEADER, P_PACK, P_BLOCK_ESC, P_TAIL, P_TAIL_ESC
	} row_phase_t;

	result_t     pixel_due[$];
	logic [15:0] row_width;
	row_phase_t  phase;
	logic [31:0] acc;
	int          deltas[16];
	logic [7:0]  widths;
	logic [31:0] esc_word;
	logic [3:0]  nbytes;
	int          didx;
	logic [15:0] left;
	logic [63:0] bits;
	int          half;
	logic        esc_long, bad, restarted;

	task automatic emit(input logic [31:0] v, input status_t st);
		result_t r;
		r.pixel = v;
		r.row_end = (left == 16'd0);
		r.run_last = 1'b0;
		r.status = st;
		pixel_due.push_back(r);
	endtask

	task automatic next_section();
		if (left >= BLOCK_PIXELS) phase = P_HEADER;
		else if (left != 16'd0) phase = P_TAIL;
		else phase = P_WAIT;
	endtask

	task automatic first_pixel(input logic [31:0] v);
		logic [15:0] w;
		status_t st;
		w = (row_width != 16'd0) ? row_width : 16'd1;
		st = restarted ? ST_RESTART : ST_OK;
		restarted = 1'b0;
		acc = v;
		left = w - 16'd1;
		emit(acc, st);
		next_section();
	endtask

	task automatic delta_pixel(input logic [31:0] d, input status_t st);
		acc = acc + d;
		left = left - 16'd1;
		emit(acc, st);
	endtask

	task automatic start_escape(input logic is_long);
		esc_long = is_long;
		nbytes = 4'd0;
		esc_word = 32'd0;
	endtask

	// Collects one escape byte; done goes high once the value is whole.
	task automatic escape_byte(input logic [7:0] b, output logic done, output logic [31:0] v);
		esc_word = esc_word | (32'(b) << (8 * nbytes[1:0]));
		nbytes = nbytes + 4'd1;
		done = (nbytes >= (esc_long ? 4'd4 : 4'd2));
		v = esc_long ? esc_word : {{16{esc_word[15]}}, esc_word[15:0]};
	endtask

	function automatic int half_width(input int h);
		return h ? int'(widths[7:4]) : int'(widths[3:0]);
	endfunction

	task automatic decode_half(input int h);
		int nb, zero_at, j;
		logic [63:0] mask;
		nb = half_width(h);
		if (nb > int'(MAX_FIELD_WIDTH)) begin
			bad = 1'b1;
			for (j = 0; j < 8; j++) deltas[h * 8 + j] = 0;
			return;
		end
		zero_at = (nb > 1) ? (1 << (nb - 1)) - 1 : 0;
		mask = (64'd1 << nb) - 64'd1;
		for (j = 0; j < 8; j++)
			deltas[h * 8 + j] = int'((bits >> (nb * j)) & mask) - zero_at;
	endtask

	// Emits block pixels until a delta asks for escape bytes.
	task automatic resolve();
		status_t st;
		st = bad ? ST_BAD_WIDTH : ST_OK;
		while (didx < 16) begin
			if (deltas[didx] == int'(DELTA_ESC_LONG) || deltas[didx] == int'(DELTA_ESC_SHORT)) begin
				phase = P_BLOCK_ESC;
				start_escape(deltas[didx] == int'(DELTA_ESC_LONG));
				return;
			end
			delta_pixel(32'(deltas[didx]), st);
			didx++;
		end
		next_section();
	endtask

	task automatic advance_pack();
		while (half < 2 && int'(nbytes) >= half_width(half)) begin
			decode_half(half);
			half++;
			nbytes = 4'd0;
			bits = 64'd0;
		end
		if (half < 2) begin
			phase = P_PACK;
			return;
		end
		didx = 0;
		resolve();
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic rs);
		int n0;
		logic done;
		logic [31:0] v;
		n0 = pixel_due.size();
		if (rs) begin
			if (phase != P_WAIT) restarted = 1'b1;
			phase = P_WAIT;
		end
		case (phase)
			P_WAIT: begin
				if (rs) begin
					if (b == BYTE_ESC_LONG) begin
						start_escape(1'b1);
						phase = P_FIRST_ESC;
					end else if (b == BYTE_ESC_SHORT) begin
						start_escape(1'b0);
						phase = P_FIRST_ESC;
					end else first_pixel(32'(b) - BYTE_BIAS);
				end
			end
			P_FIRST_ESC: begin
				escape_byte(b, done, v);
				if (done) first_pixel(v);
			end
			P_HEADER: begin
				widths = b;
				bad = 1'b0;
				half = 0;
				nbytes = 4'd0;
				bits = 64'd0;
				advance_pack();
			end
			P_PACK: begin
				if (nbytes < 4'd8) bits = bits | (64'(b) << (8 * nbytes));
				nbytes = nbytes + 4'd1;
				advance_pack();
			end
			P_BLOCK_ESC: begin
				escape_byte(b, done, v);
				if (done) begin
					delta_pixel(v, bad ? ST_BAD_WIDTH : ST_OK);
					didx++;
					resolve();
				end
			end
			P_TAIL: begin
				if (b == BYTE_ESC_LONG) begin
					start_escape(1'b1);
					phase = P_TAIL_ESC;
				end else if (b == BYTE_ESC_SHORT) begin
					start_escape(1'b0);
					phase = P_TAIL_ESC;
				end else begin
					delta_pixel(32'(b) - BYTE_BIAS, ST_OK);
					next_section();
				end
			end
			P_TAIL_ESC: begin
				escape_byte(b, done, v);
				if (done) begin
					delta_pixel(v, ST_OK);
					next_section();
				end
			end
			default: phase = P_WAIT;
		endcase
		if (pixel_due.size() > n0) pixel_due[pixel_due.size() - 1].run_last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			pixel_due.delete();
			row_width = 16'd1;
			phase = P_WAIT;
			acc = 32'd0;
			widths = 8'd0;
			esc_word = 32'd0;
			nbytes = 4'd0;
			didx = 0;
			left = 16'd0;
			bits = 64'd0;
			half = 0;
			esc_long = 1'b0;
			bad = 1'b0;
			restarted = 1'b0;
			fails = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata, m_tlast, m_tuser[0], status_t'(m_tuser[2:1])};
				if (pixel_due.size() == 0) begin
					$display("%0t: unexpected pixel beat %h (tlast %b tuser %b)",
						$time, m_tdata, m_tlast, m_tuser);
					fails++;
				end else begin
					want = pixel_due.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch pixel exp %h got %h, row_end exp %b got %b, run_last exp %b got %b, status exp %0d got %0d",
							$time, want.pixel, got.pixel, want.row_end, got.row_end,
							want.run_last, got.run_last, want.status, got.status);
						fails++;
					end
				end
			end
			if (cfg_we) row_width = cfg_wdata;
			if (s_tvalid && s_tready) predict_byte(s_tdata, s_tuser);
			pending = pixel_due.size();
		end
	end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the packed delta row decoder
// Sends well-formed compressed rows with random content, broken rows and stray
// bytes over several row widths, with random idling on both streams. The
// checker beside the block predicts and compares every pixel beat.
// ----------------------------------------------------------------------------
module testbench;
	import pdrd_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 64;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready, s_tuser;
	logic [7:0]  s_tdata;
	logic        m_tvalid, m_tlast;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	int          fails, pending;
	int          snd_idle, rcv_idle;   // idle chance in percent
	int          bytes_sent;
	int          quiet_cycles = 0;

	packed_delta_row_decoder_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	pdrd_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fails(fails), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The pixel side stalls at random; one assignment per edge.
	always @(posedge clk) m_tready <= ($urandom_range(99) >= rcv_idle);

	// Any cycle with no accepted beat on either stream counts toward the limit.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offers one byte, with random gaps first, and returns once it is taken.
	task automatic put(input logic [7:0] b, input logic rs);
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= rs;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// Width writes wait until every pixel is out and the block has settled.
	task automatic set_width(input logic [15:0] w);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// A first pixel or a tail delta: kind 0 plain byte, 1 four-byte escape, 2 two-byte escape.
	task automatic send_code(input int kind, input logic [31:0] payload, input logic rs);
		int k;
		if (kind == 1) begin
			put(BYTE_ESC_LONG, rs);
			for (k = 0; k < 4; k++) put(payload[8 * k +: 8], 1'b0);
		end else if (kind == 2) begin
			put(BYTE_ESC_SHORT, rs);
			for (k = 0; k < 2; k++) put(payload[8 * k +: 8], 1'b0);
		end else put(payload[7:0], rs);
	endtask

	task automatic send_rand_code(input logic rs);
		int r;
		r = $urandom_range(7);
		if (r == 0) send_code(1, $urandom, rs);
		else if (r == 1) send_code(2, $urandom, rs);
		else send_code(0, $urandom_range(253), rs);
	endtask

	// One 16-delta block. Only 8-bit fields can reach the escape deltas,
	// so raw values 254 and 255 are forced in often at that width.
	task automatic send_block(input int wlo, input int whi);
		logic [63:0] word;
		int raw, nb, h, j, k;
		int esc_kind[16];
		put({whi[3:0], wlo[3:0]}, 1'b0);
		for (h = 0; h < 2; h++) begin
			nb = h ? whi : wlo;
			word = 64'd0;
			for (j = 0; j < 8; j++) begin
				esc_kind[h * 8 + j] = 0;
				if (nb <= 8) begin
					raw = (nb > 0) ? $urandom_range((1 << nb) - 1) : 0;
					if (nb == 8 && $urandom_range(3) == 0) raw = 254 + $urandom_range(1);
					if (nb == 8 && raw == 255) esc_kind[h * 8 + j] = 1;
					if (nb == 8 && raw == 254) esc_kind[h * 8 + j] = 2;
					word = word | (64'(raw) << (nb * j));
				end
			end
			for (k = 0; k < nb; k++) put((nb <= 8) ? word[8 * k +: 8] : 8'($urandom), 1'b0);
		end
		for (j = 0; j < 16; j++)
			if (esc_kind[j] != 0)
				for (k = 0; k < (esc_kind[j] == 1 ? 4 : 2); k++) put(8'($urandom), 1'b0);
	endtask

	function automatic int pick_field_width();
		int r;
		r = $urandom_range(15);
		if (r == 0) return $urandom_range(9, 15);
		if (r < 6) return 8;
		return $urandom_range(8);
	endfunction

	// A whole row of w pixels; a non-negative limit cuts it after that many parts.
	task automatic send_row(input int w, input int limit);
		int i, parts;
		send_rand_code(1'b1);
		parts = 1;
		for (i = 0; i < (w - 1) / 16; i++) begin
			if (limit >= 0 && parts >= limit) return;
			send_block(pick_field_width(), pick_field_width());
			parts++;
		end
		for (i = 0; i < (w - 1) % 16; i++) begin
			if (limit >= 0 && parts >= limit) return;
			send_rand_code(1'b0);
			parts++;
		end
	endtask

	function automatic int pick_row_width();
		case ($urandom_range(9))
			0: return 1;
			1: return 16;
			2: return 17;
			3: return 32;
			4: return 33;
			default: return $urandom_range(2, 50);
		endcase
	endfunction

	initial begin
		int mode, w;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'd0;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 16'd0;
		snd_idle = 6;
		rcv_idle = 72;
		bytes_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: single-pixel rows with the byte extremes and both escapes,
		// including the most negative short and long values, then a stray byte.
		send_code(0, 32'd0, 1'b1);
		send_code(0, 32'd253, 1'b1);
		send_code(0, 32'd127, 1'b1);
		send_code(1, 32'h8000_0000, 1'b1);
		send_code(2, 32'h0000_8000, 1'b1);
		send_code(2, 32'h0000_7FFF, 1'b1);
		put(8'hFF, 1'b0);
		// One full block with escape-rich 8-bit halves, then a bad-width block.
		set_width(16'd17);
		send_code(1, 32'h7FFF_FFFF, 1'b1);
		send_block(8, 8);
		send_row(17, -1);
		send_code(0, 32'd0, 1'b1);
		send_block(9, 15);
		// Tail with both escapes, cut short by an early restart.
		set_width(16'd20);
		send_code(0, 32'd200, 1'b1);
		send_block(0, 1);
		send_code(1, 32'hFFFF_FFFF, 1'b0);
		send_code(2, 32'h0000_0001, 1'b0);
		send_code(0, 32'd5, 1'b1);
		// Widest row, started and then abandoned after two blocks.
		set_width(16'd65535);
		send_row(65535, 3);

		for (mode = 0; mode < 3; mode++) begin
			snd_idle = (mode == 0) ? 6 : (mode == 1) ? 72 : 0;
			rcv_idle = (mode == 0) ? 72 : (mode == 1) ? 6 : 0;
			w = pick_row_width();
			set_width(w[15:0]);
			while (bytes_sent < 100 * (mode + 1) + 60) begin
				if ($urandom_range(3) == 0) begin
					w = pick_row_width();
					set_width(w[15:0]);
				end
				if ($urandom_range(9) == 0) send_row(w, $urandom_range(1, 4));
				else send_row(w, -1);
				if ($urandom_range(9) == 0) put(8'($urandom), 1'b0);
			end
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fails == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: files.f
src/pdrd_pkg.sv
src/pdrd_front.sv
src/pdrd_back.sv
src/packed_delta_row_decoder_unit.sv
dv/pdrd_checker.sv
dv/testbench.sv
